// ----- sv/angle_to_pi_fraction_top_macros.svh -----
// Assertion macros shared by the checker of the angle to pi fraction block.
`ifndef ANGLE_TO_PI_FRACTION_TOP_MACROS_SVH
`define ANGLE_TO_PI_FRACTION_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define ATPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define ATPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/atpf_pkg.sv -----
// Package of the angle to pi fraction block: widths, constants, sequencer states, unit request.
package atpf_pkg;

  localparam int ANGLE_W = 64;
  localparam int NUM_W   = 48;
  localparam int DEN_W   = 32;
  localparam int QFB     = 96;            // fraction bits of the quotient
  localparam int FR_W    = QFB + 1;       // remainder and divisor width
  localparam int UNIT_W  = 114;           // shared add/sub width
  localparam int PROD_W  = NUM_W + DEN_W; // a * |p| product width
  localparam int CNT_W   = 7;             // indexes FR_W bits

  // floor(2^112 / pi)
  localparam logic [111:0] RECIP_PI = 112'h517CC1B727220A94FE13ABE8FA9A;

  localparam logic [CNT_W-1:0] MUL_LAST = 7'd63;
  localparam logic [CNT_W-1:0] DIV_TOP  = 7'd96;
  localparam logic [CNT_W-1:0] TERM_TOP = 7'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_SPLIT,
    ST_CHECK,
    ST_DIV,
    ST_TERM,
    ST_MULQ,
    ST_QSUM,
    ST_MULP,
    ST_PSUM,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              sub;
    logic [UNIT_W-1:0] x;
    logic [UNIT_W-1:0] y;
  } unit_req_t;

endpackage

// ----- sv/angle_to_pi_fraction_top.sv -----
// Top level of the angle to pi fraction block: sequencer and datapath around one add/sub unit.
//
// Turns a signed angle (radians, 48 fraction bits) into p/q, the best continued-fraction
// approximation of angle/pi whose denominator stays within cfg denominator_cap. The angle
// is multiplied by a 112-bit 1/pi constant, floored to 96 fraction bits (toward minus
// infinity for negative angles), then expanded term by term until the remainder is zero,
// the next denominator would pass the cap or the numerator would overflow, or MAX_TERMS
// terms have been examined. All arithmetic runs through a single 114-bit add/subtract
// unit, one step per cycle: the product is a shift-add multiply followed by the floor and
// split steps, and each term takes a restoring division, two shift-add multiplies and four
// check and update steps. in_stall stays high while an item is worked on. The result sits
// in an output register, so the next item is accepted while it waits on out_stall. Write
// the cap only while idle.
module angle_to_pi_fraction_top #(
  parameter int MAX_TERMS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [atpf_pkg::DEN_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [atpf_pkg::ANGLE_W-1:0]  in_angle,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [atpf_pkg::NUM_W-1:0]    out_numerator,
  output logic [atpf_pkg::DEN_W-1:0]           out_denominator
);

  localparam int TERM_W = $clog2(MAX_TERMS + 1);
  localparam int W      = atpf_pkg::UNIT_W;
  localparam int FR_W   = atpf_pkg::FR_W;
  localparam int NUM_W  = atpf_pkg::NUM_W;
  localparam int DEN_W  = atpf_pkg::DEN_W;
  localparam int PROD_W = atpf_pkg::PROD_W;
  localparam int QFB    = atpf_pkg::QFB;

  atpf_pkg::state_t state_r, state_nxt;

  logic [DEN_W-1:0]            cap_r;
  logic                        neg_r, neg_nxt;
  logic [63:0]                 mag_r, mag_nxt;
  logic [W-1:0]                acc_r, acc_nxt;
  logic                        sticky_r, sticky_nxt;
  logic [atpf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TERM_W-1:0]           term_r, term_nxt;
  logic [FR_W-1:0]             den_r, den_nxt;
  logic [FR_W-1:0]             fr_r, fr_nxt;
  logic [FR_W-1:0]             rem_r, rem_nxt;
  logic [FR_W-1:0]             quo_r, quo_nxt;
  logic [DEN_W-1:0]            a_r, a_nxt;
  logic [PROD_W-1:0]           macc_r, macc_nxt;
  logic [DEN_W-1:0]            qn_r, qn_nxt;
  logic signed [NUM_W-1:0]     p_cur_r, p_cur_nxt, p_prev_r, p_prev_nxt;
  logic [DEN_W-1:0]            q_cur_r, q_cur_nxt, q_prev_r, q_prev_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [NUM_W-1:0]     out_num_r, out_num_nxt;
  logic [DEN_W-1:0]            out_den_r, out_den_nxt;

  atpf_pkg::unit_req_t req;
  logic [W-1:0]        sum;
  logic                carry;

  atpf_addsub u_unit (.req(req), .sum(sum), .carry(carry));

  // Decision terms used by the two combinational blocks.
  logic            in_acc, out_free, fr_zero, term_done, quo_over, qn_over, p_over, pn_bad;
  logic [FR_W-1:0] rem_sh;
  logic            frac_nz;
  logic [16:0]     ip_adj;
  logic [NUM_W-1:0] p_mag;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign fr_zero   = (fr_r == '0);
  assign term_done = (term_r == TERM_W'(MAX_TERMS));
  assign quo_over  = (quo_r[FR_W-1:DEN_W] != '0) || (quo_r[DEN_W-1:0] > cap_r);
  assign qn_over   = (sum[W-1:DEN_W] != '0) || (sum[DEN_W-1:0] > cap_r);
  assign p_over    = (macc_r[PROD_W-1:50] != '0) || (macc_r[49] && (macc_r[48:0] != '0));
  assign pn_bad    = !((&sum[W-1:NUM_W-1]) || (~|sum[W-1:NUM_W-1]));
  assign rem_sh    = {rem_r[FR_W-2:0], den_r[cnt_r]};
  assign frac_nz   = (acc_r[QFB-1:0] != '0);
  assign ip_adj    = {1'b0, acc_r[111:QFB]} + {16'd0, (neg_r && frac_nz)};
  assign p_mag     = p_cur_r[NUM_W-1] ? NUM_W'(-p_cur_r) : NUM_W'(p_cur_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      atpf_pkg::ST_IDLE:  if (in_acc) state_nxt = atpf_pkg::ST_MUL;
      atpf_pkg::ST_MUL:   if (cnt_r == atpf_pkg::MUL_LAST) state_nxt = atpf_pkg::ST_FIX;
      atpf_pkg::ST_FIX:   state_nxt = atpf_pkg::ST_SPLIT;
      atpf_pkg::ST_SPLIT: state_nxt = atpf_pkg::ST_CHECK;
      atpf_pkg::ST_CHECK: begin
        state_nxt = (fr_zero || term_done) ? atpf_pkg::ST_FIN : atpf_pkg::ST_DIV;
      end
      atpf_pkg::ST_DIV:   if (cnt_r == '0) state_nxt = atpf_pkg::ST_TERM;
      atpf_pkg::ST_TERM:  state_nxt = quo_over ? atpf_pkg::ST_FIN : atpf_pkg::ST_MULQ;
      atpf_pkg::ST_MULQ:  if (cnt_r == '0) state_nxt = atpf_pkg::ST_QSUM;
      atpf_pkg::ST_QSUM:  state_nxt = qn_over ? atpf_pkg::ST_FIN : atpf_pkg::ST_MULP;
      atpf_pkg::ST_MULP:  if (cnt_r == '0) state_nxt = atpf_pkg::ST_PSUM;
      atpf_pkg::ST_PSUM: begin
        state_nxt = (p_over || pn_bad) ? atpf_pkg::ST_FIN : atpf_pkg::ST_CHECK;
      end
      atpf_pkg::ST_FIN:   if (out_free) state_nxt = atpf_pkg::ST_IDLE;
      default:            state_nxt = atpf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and unit operands.
  always_comb begin
    req           = '0;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    acc_nxt       = acc_r;
    sticky_nxt    = sticky_r;
    cnt_nxt       = cnt_r;
    term_nxt      = term_r;
    den_nxt       = den_r;
    fr_nxt        = fr_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    a_nxt         = a_r;
    macc_nxt      = macc_r;
    qn_nxt        = qn_r;
    p_cur_nxt     = p_cur_r;
    p_prev_nxt    = p_prev_r;
    q_cur_nxt     = q_cur_r;
    q_prev_nxt    = q_prev_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_num_nxt   = out_num_r;
    out_den_nxt   = out_den_r;
    unique case (state_r)
      atpf_pkg::ST_IDLE: begin
        // Latch the magnitude; the sign is applied after the floor.
        neg_nxt    = in_angle[atpf_pkg::ANGLE_W-1];
        mag_nxt    = in_angle[atpf_pkg::ANGLE_W-1] ? 64'(-in_angle) : 64'(in_angle);
        acc_nxt    = '0;
        sticky_nxt = 1'b0;
        cnt_nxt    = '0;
      end
      atpf_pkg::ST_MUL: begin
        // LSB-first shift-add; the dropped low bits feed the sticky flag.
        req.x      = acc_r;
        req.y      = mag_r[0] ? W'(atpf_pkg::RECIP_PI) : '0;
        acc_nxt    = sum >> 1;
        sticky_nxt = sticky_r | sum[0];
        mag_nxt    = mag_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
      end
      atpf_pkg::ST_FIX: begin
        req.x   = acc_r;
        req.y   = W'(neg_r && sticky_r);
        acc_nxt = sum;
      end
      atpf_pkg::ST_SPLIT: begin
        // Negative with a fraction: fraction becomes one minus it, integer part grows.
        req.sub    = 1'b1;
        req.x      = W'(1) << QFB;
        req.y      = W'(acc_r[QFB-1:0]);
        fr_nxt     = (neg_r && frac_nz) ? sum[FR_W-1:0] : {1'b0, acc_r[QFB-1:0]};
        p_cur_nxt  = neg_r ? -NUM_W'(ip_adj) : NUM_W'(ip_adj);
        p_prev_nxt = NUM_W'(1);
        q_cur_nxt  = DEN_W'(1);
        q_prev_nxt = '0;
        den_nxt    = FR_W'(1) << QFB;
        term_nxt   = '0;
      end
      atpf_pkg::ST_CHECK: begin
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = atpf_pkg::DIV_TOP;
      end
      atpf_pkg::ST_DIV: begin
        // Restoring division, one quotient bit a cycle.
        req.sub = 1'b1;
        req.x   = W'(rem_sh);
        req.y   = W'(fr_r);
        rem_nxt = carry ? sum[FR_W-1:0] : rem_sh;
        quo_nxt = {quo_r[FR_W-2:0], carry};
        cnt_nxt = cnt_r - 1'b1;
      end
      atpf_pkg::ST_TERM: begin
        den_nxt  = fr_r;
        fr_nxt   = rem_r;
        term_nxt = term_r + 1'b1;
        a_nxt    = quo_r[DEN_W-1:0];
        macc_nxt = '0;
        cnt_nxt  = atpf_pkg::TERM_TOP;
      end
      atpf_pkg::ST_MULQ: begin
        req.x    = W'(macc_r) << 1;
        req.y    = a_r[cnt_r[4:0]] ? W'(q_cur_r) : '0;
        macc_nxt = sum[PROD_W-1:0];
        cnt_nxt  = cnt_r - 1'b1;
      end
      atpf_pkg::ST_QSUM: begin
        req.x    = W'(macc_r);
        req.y    = W'(q_prev_r);
        qn_nxt   = sum[DEN_W-1:0];
        macc_nxt = '0;
        cnt_nxt  = atpf_pkg::TERM_TOP;
      end
      atpf_pkg::ST_MULP: begin
        req.x    = W'(macc_r) << 1;
        req.y    = a_r[cnt_r[4:0]] ? W'(p_mag) : '0;
        macc_nxt = sum[PROD_W-1:0];
        cnt_nxt  = cnt_r - 1'b1;
      end
      atpf_pkg::ST_PSUM: begin
        // New p = p_prev +/- a*|p|, following the sign of p.
        req.sub = p_cur_r[NUM_W-1];
        req.x   = {{(W-NUM_W){p_prev_r[NUM_W-1]}}, p_prev_r};
        req.y   = W'(macc_r);
        if (!p_over && !pn_bad) begin
          p_prev_nxt = p_cur_r;
          p_cur_nxt  = sum[NUM_W-1:0];
          q_prev_nxt = q_cur_r;
          q_cur_nxt  = qn_r;
        end
      end
      atpf_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_num_nxt   = p_cur_r;
          out_den_nxt   = q_cur_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atpf_pkg::ST_IDLE;
      cap_r       <= DEN_W'(1024);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    acc_r     <= acc_nxt;
    sticky_r  <= sticky_nxt;
    cnt_r     <= cnt_nxt;
    term_r    <= term_nxt;
    den_r     <= den_nxt;
    fr_r      <= fr_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    a_r       <= a_nxt;
    macc_r    <= macc_nxt;
    qn_r      <= qn_nxt;
    p_cur_r   <= p_cur_nxt;
    p_prev_r  <= p_prev_nxt;
    q_cur_r   <= q_cur_nxt;
    q_prev_r  <= q_prev_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
  end

  assign in_stall        = (state_r != atpf_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_numerator   = out_num_r;
  assign out_denominator = out_den_r;

endmodule

// ----- sv/atpf_addsub.sv -----
// Shared wide add/subtract unit with carry out.
module atpf_addsub (
  input  atpf_pkg::unit_req_t              req,
  output logic [atpf_pkg::UNIT_W-1:0]      sum,
  output logic                             carry
);

  logic [atpf_pkg::UNIT_W:0] full;

  // Subtract as x + ~y + 1; carry high means no borrow.
  always_comb begin
    full = {1'b0, req.x} + {1'b0, (req.sub ? ~req.y : req.y)}
         + {{atpf_pkg::UNIT_W{1'b0}}, req.sub};
  end

  assign sum   = full[atpf_pkg::UNIT_W-1:0];
  assign carry = full[atpf_pkg::UNIT_W];

endmodule

// ----- sv/atpf_checker.sv -----
// Port checker of the angle to pi fraction block and its bind to the top level.
`include "angle_to_pi_fraction_top_macros.svh"

module atpf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [atpf_pkg::NUM_W-1:0]   out_numerator,
  input logic [atpf_pkg::DEN_W-1:0]          out_denominator
);

  `ATPF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_numerator) && $stable(out_denominator), "stalled result changed")
  `ATPF_ASSERT_NOW(a_den_nonzero, out_valid, out_denominator != '0, "zero denominator")
  `ATPF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "ready right after accept")

endmodule

bind angle_to_pi_fraction_top atpf_checker u_atpf_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench of angle_to_pi_fraction_top: directed, cap sweep, random, backpressure.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import atpf_pkg::*;

  // Expected p/q for one accepted angle.
  typedef struct {
    logic signed [NUM_W-1:0] numerator;
    logic [DEN_W-1:0]        denominator;
  } fraction_t;

  localparam int MAX_TERMS = 64;
  localparam logic signed [ANGLE_W-1:0] PI_FX = 64'sh3243F6A8885A3; // pi * 2^48

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [DEN_W-1:0]           cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [ANGLE_W-1:0]  in_angle;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [NUM_W-1:0]    out_numerator;
  logic [DEN_W-1:0]           out_denominator;

  fraction_t        expected_fractions[$];
  logic [DEN_W-1:0] model_cap;
  int               error_count;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_request;

  angle_to_pi_fraction_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_angle        (in_angle),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_numerator   (out_numerator),
    .out_denominator (out_denominator)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: even the slowest legal run finishes far below this.
  initial begin
    #400_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Best continued-fraction approximation of angle/pi under the current cap.
  function automatic fraction_t approximate_over_pi(input logic signed [ANGLE_W-1:0] ang);
    fraction_t          res;
    logic               neg;
    logic [63:0]        mag;
    logic [175:0]       prod;
    logic [111:0]       fixq;
    logic [127:0]       frac;
    logic [127:0]       divisor;
    logic [127:0]       quo;
    logic [127:0]       rem;
    longint unsigned    ip;
    longint unsigned    cap;
    longint unsigned    a;
    longint unsigned    pm;
    longint unsigned    q_prev;
    longint unsigned    q_cur;
    longint unsigned    qn;
    longint             p_prev;
    longint             p_cur;
    longint             pn;
    longint             lim;
    neg    = ang[63];
    mag    = neg ? -ang : ang;
    prod   = {112'd0, mag} * {64'd0, RECIP_PI};
    fixq   = prod[175:64];
    // Floor toward minus infinity: round the magnitude up on a negative angle.
    if (neg && (prod[63:0] != 0)) fixq = fixq + 1;
    frac   = {32'd0, fixq[95:0]};
    ip     = {48'd0, fixq[111:96]};
    if (neg && frac != 0) begin
      ip   = ip + 1;
      frac = (128'd1 << QFB) - frac;
    end
    p_cur   = neg ? -longint'(ip) : longint'(ip);
    p_prev  = 1;
    q_prev  = 0;
    q_cur   = 1;
    cap     = model_cap;
    lim     = longint'(1) << (NUM_W - 1);
    divisor = 128'd1 << QFB;
    for (int step = 0; step < MAX_TERMS; step++) begin
      if (frac == 0) break;
      quo     = divisor / frac;
      rem     = divisor % frac;
      divisor = frac;
      frac    = rem;
      if (quo > {64'd0, cap}) break;
      a = quo[63:0];
      if (a > (cap - q_prev) / q_cur) break;
      pm = (p_cur < 0) ? longint'(-p_cur) : p_cur;
      if (pm != 0 && a > (64'd1 << (NUM_W + 1)) / pm) break;
      pn = ((p_cur < 0) ? -longint'(a * pm) : longint'(a * pm)) + p_prev;
      if (pn < -lim || pn > lim - 1) break;
      qn     = a * q_cur + q_prev;
      p_prev = p_cur;
      p_cur  = pn;
      q_prev = q_cur;
      q_cur  = qn;
    end
    res.numerator   = p_cur[NUM_W-1:0];
    res.denominator = q_cur[DEN_W-1:0];
    return res;
  endfunction

  // Offer one angle, idling first at the current rate; leave valid up afterwards.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= ang;
    do @(posedge clk); while (in_stall);
    expected_fractions.push_back(approximate_over_pi(ang));
  endtask

  // Drop valid and let every outstanding result drain.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_fractions.size() != 0) @(posedge clk);
  endtask

  task automatic write_cap(input logic [DEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_cap  = value;
  endtask

  function automatic logic signed [ANGLE_W-1:0] random_angle;
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return $signed({$urandom, $urandom}) >>> $urandom_range(60, 8);
      // Close to a small multiple of pi: deep expansions.
      2: return PI_FX * $signed(64'($urandom_range(40))) - 64'sd20
                + 64'($urandom_range(40));
      default: return -($signed({32'd0, $urandom}) << $urandom_range(24));
    endcase
  endfunction

  // Field extremes and the landmark angles at the reset cap.
  task automatic test_directed;
    logic signed [ANGLE_W-1:0] angles[$];
    angles = '{64'sd0, 64'sd1, -64'sd1, 64'h7FFFFFFFFFFFFFFF, 64'h8000000000000000,
               PI_FX, -PI_FX, PI_FX >>> 1, -(PI_FX >>> 1), 64'sd1 << 48,
               -(64'sd1 << 48), PI_FX * 3, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA};
    foreach (angles[i]) send_angle(angles[i]);
    drain();
  endtask

  // Zero, one, the widest cap and seven; each holds the expansion to a different depth.
  task automatic test_cap_extremes;
    logic [DEN_W-1:0] caps[$];
    caps = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'd7};
    foreach (caps[i]) begin
      write_cap(caps[i]);
      send_angle(PI_FX / 7);
      send_angle(64'sd355 <<< 40);
      send_angle(-64'sd12345678901);
      drain();
    end
  endtask

  // Random angles over four pacing modes, new cap per mode.
  task automatic test_random;
    int idle_mode[4]  = '{0, 85, 0, 37};
    int stall_mode[4] = '{0, 0, 85, 37};
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = idle_mode[m];
      recv_stall_pct = stall_mode[m];
      write_cap(m == 0 ? 32'hFFFFFFFF : $urandom_range(1 << (8 * m)));
      for (int i = 0; i < 27; i++) send_angle(random_angle());
      drain();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the receiver off long enough that the output register and input stall.
  task automatic test_backpressure;
    write_cap(32'd5);
    hold_request = 4000;
    for (int i = 0; i < 6; i++) send_angle(random_angle());
    drain();
  endtask

  // Receiver: random stall, or a long hold when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    fraction_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fractions.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d", $time, out_numerator, out_denominator);
        error_count++;
      end else begin
        want = expected_fractions.pop_front();
        if (out_numerator !== want.numerator) begin
          $display("%0t: numerator expected %0d actual %0d", $time, want.numerator,
                   out_numerator);
          error_count++;
        end
        if (out_denominator !== want.denominator) begin
          $display("%0t: denominator expected %0d actual %0d", $time, want.denominator,
                   out_denominator);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    model_cap      = 32'd1024;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_angle       = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_cap_extremes();
    test_random();
    test_backpressure();
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_fractions.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- angle_to_pi_fraction_top.f -----
+incdir+sv
sv/atpf_pkg.sv
sv/atpf_addsub.sv
sv/angle_to_pi_fraction_top.sv
sv/atpf_checker.sv
sim/testbench.sv
